// ----- rtl/core/hts_pkg.sv -----
// Shared types and constants for the HRV time-domain statistics block.
`default_nettype none
package hts_pkg;

	localparam int unsigned MAX_INTERVALS = 65536;
	localparam int unsigned CNT_W         = 17;
	localparam int unsigned SUM_W         = 28;
	localparam int unsigned SQ_W          = 40;
	localparam int unsigned PROD_W        = 57;
	localparam int unsigned NUM_W         = 66;
	localparam int unsigned DEN_W         = 33;
	localparam int unsigned ROOT_W        = 64;
	localparam logic [11:0] THRESHOLD_RESET = 12'd50;
	localparam logic [14:0] PCT_SCALE       = 15'd25600;

	typedef struct packed {
		logic [11:0] rr_interval_ms;
		logic        last_interval;
	} in_item_t;

	typedef struct packed {
		logic [15:0] mean_rr;
		logic [15:0] sd_rr;
		logic [15:0] rmssd_value;
		logic [15:0] nn50_count;
		logic [14:0] pnn50_percent;
		logic [16:0] interval_count;
		logic        overflow_flag;
	} out_item_t;

	// Snapshot of one finished record, handed from front to back.
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sumsq;
		logic [SQ_W-1:0]  diffsq;
		logic [15:0]      nn;
		logic             ovf;
	} rec_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL_A,
		B_MUL_B,
		B_DIV_SD,
		B_SQRT_SD,
		B_DIV_MEAN,
		B_DIV_RMS,
		B_SQRT_RMS,
		B_DIV_PNN,
		B_FIN
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/hts_front.sv -----
// Front end: accepts intervals, keeps the running sums and closes records.
`default_nettype none
module hts_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire hts_pkg::in_item_t item,
	input  wire logic            cfg_we,
	input  wire logic [11:0]     cfg_wdata,
	output hts_pkg::rec_t        rec,
	output logic                 rec_push
);
	logic [11:0]                   thr_q;
	logic [hts_pkg::CNT_W-1:0]     cnt_q;
	logic [hts_pkg::SUM_W-1:0]     sum_q;
	logic [hts_pkg::SQ_W-1:0]      sumsq_q;
	logic [hts_pkg::SQ_W-1:0]      diffsq_q;
	logic [15:0]                   nn_q;
	logic [11:0]                   prev_q;
	logic                          ovf_q;
	logic                          room;
	logic [11:0]                   d;
	hts_pkg::rec_t                 nxt;

	assign room = cnt_q < hts_pkg::CNT_W'(hts_pkg::MAX_INTERVALS);
	assign d = (item.rr_interval_ms >= prev_q) ? item.rr_interval_ms - prev_q
	                                           : prev_q - item.rr_interval_ms;

	always_comb begin
		nxt.n      = cnt_q;
		nxt.sum    = sum_q;
		nxt.sumsq  = sumsq_q;
		nxt.diffsq = diffsq_q;
		nxt.nn     = nn_q;
		nxt.ovf    = ovf_q;
		if (room) begin
			if (cnt_q != '0) begin
				nxt.diffsq = diffsq_q + hts_pkg::SQ_W'(24'(d) * 24'(d));
				if (d > thr_q && nn_q != 16'hFFFF) nxt.nn = nn_q + 16'd1;
			end
			nxt.sum   = sum_q + hts_pkg::SUM_W'(item.rr_interval_ms);
			nxt.sumsq = sumsq_q + hts_pkg::SQ_W'(24'(item.rr_interval_ms) *
			                                     24'(item.rr_interval_ms));
			nxt.n     = cnt_q + 1'b1;
		end else begin
			nxt.ovf = 1'b1;
		end
	end

	assign rec      = nxt;
	assign rec_push = accept && item.last_interval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= hts_pkg::THRESHOLD_RESET;
			cnt_q    <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
			diffsq_q <= '0;
			nn_q     <= '0;
			prev_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (accept) begin
				if (item.last_interval) begin
					cnt_q    <= '0;
					sum_q    <= '0;
					sumsq_q  <= '0;
					diffsq_q <= '0;
					nn_q     <= '0;
					prev_q   <= '0;
					ovf_q    <= 1'b0;
				end else begin
					cnt_q    <= nxt.n;
					sum_q    <= nxt.sum;
					sumsq_q  <= nxt.sumsq;
					diffsq_q <= nxt.diffsq;
					nn_q     <= nxt.nn;
					ovf_q    <= nxt.ovf;
					if (room) prev_q <= item.rr_interval_ms;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hts_fifo.sv -----
// Two-entry queue of finished records between front and back.
`default_nettype none
module hts_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire hts_pkg::rec_t wdata,
	input  wire logic          rd,
	output hts_pkg::rec_t      rdata,
	output logic               full,
	output logic               empty
);
	hts_pkg::rec_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hts_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hts_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [hts_pkg::NUM_W-1:0] num,
	input  wire logic [hts_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic [hts_pkg::NUM_W-1:0]      quot
);
	localparam int unsigned STEP_W = $clog2(hts_pkg::NUM_W + 1);

	logic [hts_pkg::NUM_W-1:0] nq_q;
	logic [hts_pkg::DEN_W-1:0] rem_q;
	logic [hts_pkg::DEN_W-1:0] den_q;
	logic [STEP_W-1:0]         step_q;
	logic                      busy_q;
	logic [hts_pkg::DEN_W:0]   trial;
	logic                      ge;

	assign trial = {rem_q, nq_q[hts_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign quot  = nq_q;

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? hts_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[hts_pkg::DEN_W-1:0];
			nq_q  <= {nq_q[hts_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(hts_pkg::NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hts_back.sv -----
// Back end: sequences multiplies, divides and roots for one record at a time.
`default_nettype none
module hts_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hts_pkg::rec_t rec_in,
	input  wire logic          rec_valid,
	output logic               rec_pop,
	output hts_pkg::out_item_t out_data,
	output logic               out_valid,
	input  wire logic          out_pop
);
	hts_pkg::back_state_t             state_q, state_d;
	hts_pkg::rec_t                    rec_q;
	logic [hts_pkg::PROD_W-1:0]       acc_q, mcand_q, a_q, dev;
	logic [hts_pkg::SUM_W-1:0]        y_q;
	logic [hts_pkg::DEN_W-1:0]        nsq_q;
	logic [hts_pkg::ROOT_W-1:0]       v_q, res_q, bit_q, tst;
	logic [15:0]                      mean_q, sd_q, rms_q;
	logic [14:0]                      pnn_q;
	logic [hts_pkg::CNT_W-1:0]        m;
	logic [15:0]                      root_sat;
	logic                             div_start, div_done;
	logic [hts_pkg::NUM_W-1:0]        div_num, div_quot;
	logic [hts_pkg::DEN_W-1:0]        div_den;
	hts_pkg::out_item_t               out_q;
	logic                             out_valid_q;

	assign m        = rec_q.n - 1'b1;
	assign dev      = (a_q >= acc_q) ? a_q - acc_q : '0;
	assign tst      = res_q + bit_q;
	assign root_sat = (res_q[hts_pkg::ROOT_W-1:16] != '0) ? 16'hFFFF : res_q[15:0];
	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	hts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hts_pkg::B_IDLE: begin
				if (rec_valid && !out_valid_q)
					state_d = (rec_in.n == '0) ? hts_pkg::B_FIN : hts_pkg::B_MUL_A;
			end
			hts_pkg::B_MUL_A:    if (y_q == '0) state_d = hts_pkg::B_MUL_B;
			hts_pkg::B_MUL_B:    if (y_q == '0) state_d = hts_pkg::B_DIV_SD;
			hts_pkg::B_DIV_SD:   if (div_done) state_d = hts_pkg::B_SQRT_SD;
			hts_pkg::B_SQRT_SD:  if (bit_q == '0) state_d = hts_pkg::B_DIV_MEAN;
			hts_pkg::B_DIV_MEAN: begin
				if (div_done)
					state_d = (rec_q.n > hts_pkg::CNT_W'(1)) ? hts_pkg::B_DIV_RMS : hts_pkg::B_FIN;
			end
			hts_pkg::B_DIV_RMS:  if (div_done) state_d = hts_pkg::B_SQRT_RMS;
			hts_pkg::B_SQRT_RMS: if (bit_q == '0) state_d = hts_pkg::B_DIV_PNN;
			hts_pkg::B_DIV_PNN:  if (div_done) state_d = hts_pkg::B_FIN;
			hts_pkg::B_FIN:      state_d = hts_pkg::B_IDLE;
			default:             state_d = hts_pkg::B_IDLE;
		endcase
	end

	// The divider is started on the edge that enters a divide state.
	always_comb begin
		rec_pop   = (state_q == hts_pkg::B_IDLE) && (state_d != hts_pkg::B_IDLE);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_d)
			hts_pkg::B_DIV_SD: begin
				div_num = hts_pkg::NUM_W'({dev, 8'd0});
				div_den = nsq_q;
			end
			hts_pkg::B_DIV_MEAN: begin
				div_num = hts_pkg::NUM_W'({rec_q.sum, 4'd0});
				div_den = hts_pkg::DEN_W'(rec_q.n);
			end
			hts_pkg::B_DIV_RMS: begin
				div_num = hts_pkg::NUM_W'({rec_q.diffsq, 8'd0});
				div_den = hts_pkg::DEN_W'(m);
			end
			hts_pkg::B_DIV_PNN: begin
				div_num = hts_pkg::NUM_W'(31'(rec_q.nn) * 31'(hts_pkg::PCT_SCALE));
				div_den = hts_pkg::DEN_W'(m);
			end
			default: ;
		endcase
		if (state_d != state_q &&
		    (state_d == hts_pkg::B_DIV_SD || state_d == hts_pkg::B_DIV_MEAN ||
		     state_d == hts_pkg::B_DIV_RMS || state_d == hts_pkg::B_DIV_PNN))
			div_start = 1'b1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hts_pkg::B_IDLE: begin
				if (rec_pop) begin
					rec_q   <= rec_in;
					acc_q   <= '0;
					mcand_q <= hts_pkg::PROD_W'(rec_in.sumsq);
					y_q     <= hts_pkg::SUM_W'(rec_in.n);
					nsq_q   <= hts_pkg::DEN_W'(34'(rec_in.n) * 34'(rec_in.n));
					mean_q  <= '0;
					sd_q    <= '0;
					rms_q   <= '0;
					pnn_q   <= '0;
				end
			end
			hts_pkg::B_MUL_A, hts_pkg::B_MUL_B: begin
				if (y_q != '0) begin
					if (y_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q <= mcand_q << 1;
					y_q     <= y_q >> 1;
				end else if (state_q == hts_pkg::B_MUL_A) begin
					a_q     <= acc_q;
					acc_q   <= '0;
					mcand_q <= hts_pkg::PROD_W'(rec_q.sum);
					y_q     <= rec_q.sum;
				end
			end
			hts_pkg::B_DIV_SD, hts_pkg::B_DIV_RMS: begin
				if (div_done) begin
					v_q   <= div_quot[hts_pkg::ROOT_W-1:0];
					res_q <= '0;
					bit_q <= hts_pkg::ROOT_W'(1) << (hts_pkg::ROOT_W - 2);
				end
			end
			hts_pkg::B_SQRT_SD, hts_pkg::B_SQRT_RMS: begin
				if (bit_q != '0) begin
					if (v_q >= tst) begin
						v_q   <= v_q - tst;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (state_q == hts_pkg::B_SQRT_SD) begin
					sd_q <= root_sat;
				end else begin
					rms_q <= root_sat;
				end
			end
			hts_pkg::B_DIV_MEAN: begin
				if (div_done)
					mean_q <= (div_quot[hts_pkg::NUM_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
			end
			hts_pkg::B_DIV_PNN: begin
				if (div_done)
					pnn_q <= (div_quot[hts_pkg::NUM_W-1:15] != '0) ? 15'h7FFF : div_quot[14:0];
			end
			hts_pkg::B_FIN: begin
				out_q.mean_rr        <= mean_q;
				out_q.sd_rr          <= sd_q;
				out_q.rmssd_value    <= rms_q;
				out_q.nn50_count     <= (rec_q.n > hts_pkg::CNT_W'(1)) ? rec_q.nn : 16'd0;
				out_q.pnn50_percent  <= pnn_q;
				out_q.interval_count <= rec_q.n;
				out_q.overflow_flag  <= rec_q.ovf;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hts_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hts_pkg::B_FIN) out_valid_q <= 1'b1;
			else if (out_pop) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/hrv_time_domain_stats.sv -----
// Top level of the HRV time-domain statistics block (mean, SDNN, RMSSD, NN50, pNN50).
//
//   channel   direction  handshake        payload
//   input     in         push / full      in_data  (hts_pkg::in_item_t)
//   result    out        pop / empty      out_data (hts_pkg::out_item_t)
//   config    in         cfg_we           cfg_wdata (NN50 threshold, ms)
//
// The front takes one interval per cycle while the queue is not full; a request marked
// last closes the record. The back then works on each record with up to four divides,
// two square roots and two shift-add multiplies. Two closed records can wait in the
// queue; full rises while it holds both. The back starts no new record while a finished
// result waits to be popped. Reset is asynchronous and needs no clearing pass; the
// threshold resets to 50 ms.
`default_nettype none
module hrv_time_domain_stats (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire hts_pkg::in_item_t  in_data,
	output logic                    empty,
	input  wire logic               pop,
	output hts_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [11:0]        cfg_wdata
);
	hts_pkg::rec_t rec_wr, rec_rd;
	logic          rec_push, rec_pop, q_empty, out_valid;

	hts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push && !full),
		.item     (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rec      (rec_wr),
		.rec_push (rec_push)
	);

	hts_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (rec_push),
		.wdata (rec_wr),
		.rd    (rec_pop),
		.rdata (rec_rd),
		.full  (full),
		.empty (q_empty)
	);

	hts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_in   (rec_rd),
		.rec_valid(!q_empty),
		.rec_pop  (rec_pop),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_pop  (pop)
	);

	assign empty = !out_valid;
endmodule
`default_nettype wire

// ----- rtl/core/hts_checker.sv -----
// Port-level checker for the HRV statistics block, bound to the top level.
`default_nettype none
module hts_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire hts_pkg::out_item_t out_data
);
	// A taken result is never replaced by a new one in the very next cycle.
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> empty)
		else $error("result still shown after it was taken");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data))
		else $error("waiting result changed or vanished");

	a_short_record: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_data.interval_count < 17'd2 |->
		out_data.rmssd_value == 16'd0 && out_data.nn50_count == 16'd0 &&
		out_data.pnn50_percent == 15'd0)
		else $error("difference statistics nonzero for a short record");

	a_pnn_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_data.pnn50_percent <= 15'd25600 &&
		17'(out_data.nn50_count) <= out_data.interval_count)
		else $error("pNN50 or NN50 out of range");
endmodule

bind hrv_time_domain_stats hts_checker u_hts_checker (.*);
`default_nettype wire
